FILE: hdl/opt_pkg.sv
// ----------------------------------------------------------------------------
// opt_pkg
// Shared types, constants and sine table for the odometry pose tracker.
// ----------------------------------------------------------------------------
package opt_pkg;

    localparam int POS_WIDTH       = 32;
    localparam int TRIG_TABLE_BITS = 10;

    localparam int HEADING_W = 16;
    localparam int TRAVEL_W  = 16;
    localparam int LOAD_W    = 32;
    localparam int OUT_POS_W = 32;
    localparam int SUM_W     = TRAVEL_W + 1;
    localparam int TRIG_W    = 16;
    localparam int PROD_W    = SUM_W + TRIG_W;
    localparam int STEP_W    = PROD_W + 1 - 16;
    localparam int WIDE_W    = ((POS_WIDTH > LOAD_W) ? POS_WIDTH : LOAD_W) + 2;

    // heading units: 1/128 degree
    localparam int FULL_CIRCLE = 46080;
    localparam int HALF_CIRCLE = 23040;
    localparam int ANGLE_W     = 16;

    // table index = floor(num / FULL_CIRCLE) by exact reciprocal multiply
    localparam int NUM_W       = ANGLE_W + TRIG_TABLE_BITS;
    localparam int RECIP_SHIFT = NUM_W + 16;
    localparam int RECIP_W     = NUM_W + 1;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + FULL_CIRCLE - 1) / FULL_CIRCLE;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    localparam int QIDX_W  = TRIG_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QIDX_W;

    localparam int QUEUE_DEPTH = 4;  // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;

    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [HEADING_W-1:0] HEADING_MAX = 16'sh7fff;
    localparam logic signed [HEADING_W-1:0] HEADING_MIN = 16'sh8000;

    localparam logic       OP_UPDATE = 1'b0;
    localparam logic       OP_LOAD   = 1'b1;

    localparam logic [2:0] MOTION_STOP  = 3'd0;
    localparam logic [2:0] MOTION_FWD   = 3'd1;
    localparam logic [2:0] MOTION_BWD   = 3'd2;
    localparam logic [2:0] MOTION_LEFT  = 3'd3;
    localparam logic [2:0] MOTION_RIGHT = 3'd4;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_HEADING,
        CMD_FWD,
        CMD_BWD,
        CMD_LOAD
    } cmd_t;

    typedef struct packed {
        logic                        op;
        logic [2:0]                  motion;
        logic signed [HEADING_W-1:0] measured_heading;
        logic signed [TRAVEL_W-1:0]  left_travel;
        logic signed [TRAVEL_W-1:0]  right_travel;
        logic signed [LOAD_W-1:0]    load_x;
        logic signed [LOAD_W-1:0]    load_y;
        logic signed [HEADING_W-1:0] load_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_POS_W-1:0] pos_x;
        logic signed [OUT_POS_W-1:0] pos_y;
        logic signed [HEADING_W-1:0] heading;
    } out_item_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic signed [HEADING_W-1:0] heading;
        logic signed [LOAD_W-1:0]    load_x;
        logic signed [LOAD_W-1:0]    load_y;
    } front_data_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic signed [HEADING_W-1:0] heading;
        logic signed [STEP_W-1:0]    dx;
        logic signed [STEP_W-1:0]    dy;
        logic signed [LOAD_W-1:0]    load_x;
        logic signed [LOAD_W-1:0]    load_y;
    } queue_item_t;

    typedef logic signed [TRIG_W-1:0] sin_table_t [QUARTER];

    // first-quadrant sine, Taylor series to x^11 in Q2.30, rounded to Q1.15
    function automatic logic signed [TRIG_W-1:0] sin_quarter(input int unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (64'(m) * TWO_PI_Q30) >> TRIG_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) / 110) >> 30);
        t  = ONE_Q30 - (((x2 * t) / 72) >> 30);
        t  = ONE_Q30 - (((x2 * t) / 42) >> 30);
        t  = ONE_Q30 - (((x2 * t) / 20) >> 30);
        t  = ONE_Q30 - (((x2 * t) / 6) >> 30);
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return TRIG_W'(s);
    endfunction

    function automatic sin_table_t build_sin_table();
        sin_table_t tbl;
        for (int i = 0; i < QUARTER; i++) begin
            tbl[i] = sin_quarter(i);
        end
        return tbl;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();
    localparam logic signed [TRIG_W-1:0] SIN_END = sin_quarter(QUARTER);

    // full-circle lookup by quarter-wave symmetry
    function automatic logic signed [TRIG_W-1:0] trig_lookup(
        input logic [TRIG_TABLE_BITS-1:0] k
    );
        logic [1:0]               q;
        logic [QIDX_W-1:0]        m;
        logic [QIDX_W-1:0]        mirror;
        logic signed [TRIG_W-1:0] v;
        q      = k[TRIG_TABLE_BITS-1 -: 2];
        m      = k[QIDX_W-1:0];
        mirror = ~m + QIDX_W'(1);
        if (q[0]) begin
            v = (m == '0) ? SIN_END : SIN_TABLE[mirror];
        end else begin
            v = SIN_TABLE[m];
        end
        return q[1] ? -v : v;
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(POS_MAX);
        lo = WIDE_W'(POS_MIN);
        if (v > hi) begin
            return POS_MAX;
        end else if (v < lo) begin
            return POS_MIN;
        end
        return v[POS_WIDTH-1:0];
    endfunction

endpackage

FILE: hdl/opt_front.sv
// ----------------------------------------------------------------------------
// opt_front
// Accepts items, classifies them and computes the position step:
// heading negate, table index, sine/cosine lookup, travel products.
// ----------------------------------------------------------------------------
module opt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  opt_pkg::in_item_t    s_item,
    output logic                 push_valid,
    output opt_pkg::queue_item_t push_item,
    input  logic                 queue_full
);
    import opt_pkg::*;

    logic front_en;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    front_data_t d1_reg, d2_reg, d3_reg, d4_reg;
    front_data_t d1_next;

    logic [NUM_W-1:0]           num1_reg, num1_next;
    logic signed [SUM_W-1:0]    sum1_reg, sum1_next;
    logic signed [SUM_W-1:0]    sum2_reg, sum3_reg;
    logic [TRIG_TABLE_BITS-1:0] k2_reg, k2_next;
    logic signed [TRIG_W-1:0]   sin3_reg, sin3_next;
    logic signed [TRIG_W-1:0]   cos3_reg, cos3_next;
    logic signed [PROD_W-1:0]   px4_reg, px4_next;
    logic signed [PROD_W-1:0]   py4_reg, py4_next;

    logic signed [HEADING_W-1:0]   heading_neg;
    logic signed [ANGLE_W:0]       angle_wide;
    logic [ANGLE_W-1:0]            angle;
    logic [NUM_W+RECIP_W-1:0]      recip_prod;
    logic signed [PROD_W:0]        rx;
    logic signed [PROD_W:0]        ry;

    assign front_en   = !v4_reg || !queue_full;
    assign s_ready    = front_en;
    assign push_valid = v4_reg && !queue_full;

    // stage 1: classify, heading, angle numerator, travel sum
    always_comb begin
        heading_neg = (s_item.measured_heading == HEADING_MIN) ? HEADING_MAX
                                                               : -s_item.measured_heading;
        angle_wide  = (ANGLE_W+1)'(heading_neg)
                    + ((heading_neg < 0) ? (ANGLE_W+1)'(FULL_CIRCLE) : '0);
        angle       = angle_wide[ANGLE_W-1:0];
        num1_next   = {angle, {TRIG_TABLE_BITS{1'b0}}} + NUM_W'(HALF_CIRCLE);
        sum1_next   = SUM_W'(s_item.left_travel) + SUM_W'(s_item.right_travel);

        d1_next.heading = heading_neg;
        d1_next.load_x  = s_item.load_x;
        d1_next.load_y  = s_item.load_y;
        if (s_item.op == OP_LOAD) begin
            d1_next.cmd     = CMD_LOAD;
            d1_next.heading = s_item.load_heading;
        end else begin
            unique case (s_item.motion) inside
                MOTION_FWD:                             d1_next.cmd = CMD_FWD;
                MOTION_BWD:                             d1_next.cmd = CMD_BWD;
                MOTION_STOP, MOTION_LEFT, MOTION_RIGHT: d1_next.cmd = CMD_HEADING;
                default:                                d1_next.cmd = CMD_HOLD;
            endcase
        end
    end

    // stage 2: table index
    assign recip_prod = (NUM_W+RECIP_W)'(num1_reg) * (NUM_W+RECIP_W)'(RECIP);
    assign k2_next    = recip_prod[RECIP_SHIFT +: TRIG_TABLE_BITS];

    // stage 3: sine and cosine
    assign sin3_next = trig_lookup(k2_reg);
    assign cos3_next = trig_lookup(k2_reg + TRIG_TABLE_BITS'(QUARTER));

    // stage 4: travel products
    assign px4_next = PROD_W'(sum3_reg) * PROD_W'(cos3_reg);
    assign py4_next = PROD_W'(sum3_reg) * PROD_W'(sin3_reg);

    // step = round(sum * trig / 2^16), floor shift
    always_comb begin
        rx = (PROD_W+1)'(px4_reg) + (PROD_W+1)'(32768);
        ry = (PROD_W+1)'(py4_reg) + (PROD_W+1)'(32768);
        push_item.cmd     = d4_reg.cmd;
        push_item.heading = d4_reg.heading;
        push_item.load_x  = d4_reg.load_x;
        push_item.load_y  = d4_reg.load_y;
        push_item.dx      = STEP_W'(rx >>> 16);
        push_item.dy      = STEP_W'(ry >>> 16);
    end

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        v4_next = v4_reg;
        if (front_en) begin
            v1_next = s_valid;
            v2_next = v1_reg;
            v3_next = v2_reg;
            v4_next = v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_en) begin
            d1_reg   <= d1_next;
            num1_reg <= num1_next;
            sum1_reg <= sum1_next;
            d2_reg   <= d1_reg;
            k2_reg   <= k2_next;
            sum2_reg <= sum1_reg;
            d3_reg   <= d2_reg;
            sin3_reg <= sin3_next;
            cos3_reg <= cos3_next;
            sum3_reg <= sum2_reg;
            d4_reg   <= d3_reg;
            px4_reg  <= px4_next;
            py4_reg  <= py4_next;
        end
    end

endmodule

FILE: hdl/opt_queue.sv
// ----------------------------------------------------------------------------
// opt_queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module opt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  opt_pkg::queue_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output opt_pkg::queue_item_t head_item,
    output logic                 empty
);
    import opt_pkg::*;

    queue_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/opt_back.sv
// ----------------------------------------------------------------------------
// opt_back
// Pose accumulator: applies one queued item per cycle with saturation while
// the output register is free or read, and holds the result in it.
// ----------------------------------------------------------------------------
module opt_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  opt_pkg::queue_item_t head_item,
    input  logic                 queue_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output opt_pkg::out_item_t   m_item
);
    import opt_pkg::*;

    logic signed [POS_WIDTH-1:0] x_reg, x_next;
    logic signed [POS_WIDTH-1:0] y_reg, y_next;
    logic signed [HEADING_W-1:0] heading_reg, heading_next;
    logic                        m_valid_reg, m_valid_next;
    out_item_t                   out_reg, out_next;

    logic signed [WIDE_W-1:0] x_wide, y_wide, dx_wide, dy_wide;

    assign pop     = !queue_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        x_wide       = WIDE_W'(x_reg);
        y_wide       = WIDE_W'(y_reg);
        dx_wide      = WIDE_W'(head_item.dx);
        dy_wide      = WIDE_W'(head_item.dy);
        x_next       = x_reg;
        y_next       = y_reg;
        heading_next = heading_reg;
        if (pop) begin
            unique case (head_item.cmd)
                CMD_LOAD: begin
                    x_next       = sat_pos(WIDE_W'(head_item.load_x));
                    y_next       = sat_pos(WIDE_W'(head_item.load_y));
                    heading_next = head_item.heading;
                end
                CMD_FWD: begin
                    x_next       = sat_pos(x_wide + dx_wide);
                    y_next       = sat_pos(y_wide + dy_wide);
                    heading_next = head_item.heading;
                end
                CMD_BWD: begin
                    x_next       = sat_pos(x_wide - dx_wide);
                    y_next       = sat_pos(y_wide - dy_wide);
                    heading_next = head_item.heading;
                end
                CMD_HEADING: begin
                    heading_next = head_item.heading;
                end
                CMD_HOLD: begin
                end
                default: begin
                end
            endcase
        end

        out_next.pos_x   = OUT_POS_W'(WIDE_W'(x_next));
        out_next.pos_y   = OUT_POS_W'(WIDE_W'(y_next));
        out_next.heading = heading_next;

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            heading_reg <= heading_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: hdl/odometry_pose_tracker.sv
// ----------------------------------------------------------------------------
// odometry_pose_tracker
// Differential-drive dead-reckoning pose tracker, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry update or load items; m_valid/m_ready/m_item
//   carry one pose result (x, y in 1/16 mm, heading in 1/128 degree) per item,
//   in the order the items were accepted.
//   Path from acceptance to m_valid with an empty queue: four front stages
//   (classify, table index multiply, sine/cosine lookup, travel products),
//   one queue write, then the accumulator loads the output register.
//   Throughput: one item per cycle while m_ready is high, set by the pose accumulator.
//   Reset (aresetn low, synchronous): pose cleared to zero, pipeline and queue
//   emptied, m_valid low; s_ready is high on the cycle after reset.
//   Receiver stall: the output register holds its item, the 4-entry queue
//   fills behind it, and once the queue is full and the last front stage holds
//   an item, s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module odometry_pose_tracker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  opt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output opt_pkg::out_item_t m_item
);
    import opt_pkg::*;

    logic        push_valid;
    queue_item_t push_item;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;
    queue_item_t head_item;

    opt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    opt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    opt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_item   (head_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

FILE: hdl/opt_checker.sv
// ----------------------------------------------------------------------------
// opt_checker
// Port-level checks for the pose tracker, bound to the top level.
// ----------------------------------------------------------------------------
module opt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input opt_pkg::out_item_t m_item
);
    import opt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind odometry_pose_tracker opt_checker u_checker (.*);

FILE: dv/tb_odometry_pose_tracker.sv
// ----------------------------------------------------------------------------
// tb_odometry_pose_tracker
// Self-checking bench for the dead-reckoning pose tracker. Directed items hit
// heading and travel extremes, every motion code, negation overflow, out-of-range
// headings and position saturation. Random items follow, mostly forward and
// backward updates with occasional loads, most near position limits. A local
// fixed-point predictor tracks the pose and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_odometry_pose_tracker;
    import opt_pkg::*;

    localparam logic [2:0] MOTION_HOLD_LO = 3'd5;
    localparam logic [2:0] MOTION_HOLD_HI = 3'd7;
    localparam int TABLE_LEN    = 1 << TRIG_TABLE_BITS;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 1880;

    class pose_book;
        longint                      pos_x_q;
        longint                      pos_y_q;
        logic signed [HEADING_W-1:0] heading_q;
        int                          wave [TABLE_LEN];
        out_item_t                   pending_poses [$];
        int                          mismatch_count;

        function new();
            int unsigned quad;
            int unsigned m;
            int          v;
            for (int k = 0; k < TABLE_LEN; k++) begin
                quad = k >> (TRIG_TABLE_BITS - 2);
                m    = k & (QUARTER - 1);
                v    = quad[0] ? quadrant_sine(QUARTER - m) : quadrant_sine(m);
                wave[k] = quad[1] ? -v : v;
            end
            pos_x_q        = 0;
            pos_y_q        = 0;
            heading_q      = '0;
            mismatch_count = 0;
        endfunction

        // first quadrant sine, Taylor to x^11 in Q2.30, rounded to Q1.15
        function int quadrant_sine(int unsigned m);
            longint unsigned mm;
            longint unsigned arg;
            longint unsigned arg_sq;
            longint unsigned acc;
            longint unsigned s;
            longint unsigned divs [5];
            divs   = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            mm     = m;
            arg    = (mm * TWO_PI_Q30) >> TRIG_TABLE_BITS;
            arg_sq = (arg * arg) >> 30;
            acc    = ONE_Q30;
            foreach (divs[i]) begin
                acc = ONE_Q30 - (((arg_sq * acc) / divs[i]) >> 30);
            end
            s = (arg * acc) >> 30;
            s = (s + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            return int'(s);
        endfunction

        function longint clamp_pos(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                return hi;
            end else if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function longint travel_step(int sum, int trig);
            longint p;
            p = longint'(sum) * longint'(trig);
            return (p + (longint'(1) <<< 15)) >>> 16;
        endfunction

        function void take_item(in_item_t it);
            int          h;
            int          a;
            int          sum;
            int unsigned idx;
            longint      lx;
            longint      ly;
            longint      dx;
            longint      dy;
            out_item_t   pose;
            if (it.op == OP_LOAD) begin
                lx        = it.load_x;
                ly        = it.load_y;
                pos_x_q   = clamp_pos(lx);
                pos_y_q   = clamp_pos(ly);
                heading_q = it.load_heading;
            end else if (it.motion <= MOTION_RIGHT) begin
                h = it.measured_heading;
                h = -h;
                if (h > int'(HEADING_MAX)) begin
                    h = HEADING_MAX;
                end
                heading_q = HEADING_W'(h);
                if (it.motion == MOTION_FWD || it.motion == MOTION_BWD) begin
                    a = h % FULL_CIRCLE;
                    if (a < 0) begin
                        a += FULL_CIRCLE;
                    end
                    idx = int'(((longint'(a) << TRIG_TABLE_BITS) + HALF_CIRCLE)
                                / FULL_CIRCLE);
                    idx = idx % TABLE_LEN;
                    sum = int'(it.left_travel) + int'(it.right_travel);
                    dx  = travel_step(sum, wave[(idx + QUARTER) % TABLE_LEN]);
                    dy  = travel_step(sum, wave[idx]);
                    if (it.motion == MOTION_FWD) begin
                        pos_x_q = clamp_pos(pos_x_q + dx);
                        pos_y_q = clamp_pos(pos_y_q + dy);
                    end else begin
                        pos_x_q = clamp_pos(pos_x_q - dx);
                        pos_y_q = clamp_pos(pos_y_q - dy);
                    end
                end
            end
            pose.pos_x   = pos_x_q[OUT_POS_W-1:0];
            pose.pos_y   = pos_y_q[OUT_POS_W-1:0];
            pose.heading = heading_q;
            pending_poses.push_back(pose);
        endfunction

        function void field_diff(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_pose(out_item_t got);
            out_item_t want;
            if (pending_poses.size() == 0) begin
                $display("%0t unexpected pose: expected none actual x=%0d y=%0d heading=%0d",
                         $time, got.pos_x, got.pos_y, got.heading);
                mismatch_count++;
                return;
            end
            want = pending_poses.pop_front();
            field_diff("pos_x", want.pos_x, got.pos_x);
            field_diff("pos_y", want.pos_y, got.pos_y);
            field_diff("heading", want.heading, got.heading);
        endfunction

        function int outstanding();
            return pending_poses.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic      quiet   = 1'b0;
    pose_book  book;

    odometry_pose_tracker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                book.take_item(s_item);
            end
            if (m_valid && m_ready) begin
                book.check_pose(m_item);
            end
        end
    end

    function automatic in_item_t noisy_item();
        in_item_t it;
        it.op               = 1'($urandom);
        it.motion           = 3'($urandom);
        it.measured_heading = 16'($urandom);
        it.left_travel      = 16'($urandom);
        it.right_travel     = 16'($urandom);
        it.load_x           = 32'($urandom);
        it.load_y           = 32'($urandom);
        it.load_heading     = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t update_item(logic [2:0] motion,
                                             logic signed [15:0] meas,
                                             logic signed [15:0] left,
                                             logic signed [15:0] right);
        in_item_t it;
        it                  = noisy_item();
        it.op               = OP_UPDATE;
        it.motion           = motion;
        it.measured_heading = meas;
        it.left_travel      = left;
        it.right_travel     = right;
        return it;
    endfunction

    function automatic in_item_t load_item(logic signed [31:0] lx, logic signed [31:0] ly,
                                           logic signed [15:0] lh);
        in_item_t it;
        it              = noisy_item();
        it.op           = OP_LOAD;
        it.load_x       = lx;
        it.load_y       = ly;
        it.load_heading = lh;
        return it;
    endfunction

    function automatic in_item_t draw_item();
        in_item_t it;
        int       r;
        it = noisy_item();
        r  = $urandom_range(0, 99);
        if (r < 8) begin
            it.op = OP_LOAD;
            case ($urandom_range(0, 2))
                0: begin
                    it.load_x = LOAD_W'(POS_MAX - $urandom_range(0, 100000));
                    it.load_y = LOAD_W'(POS_MIN + $urandom_range(0, 100000));
                end
                1: begin
                    it.load_x = LOAD_W'(POS_MIN + $urandom_range(0, 100000));
                    it.load_y = LOAD_W'(POS_MAX - $urandom_range(0, 100000));
                end
                default: begin
                end
            endcase
            if ($urandom_range(0, 9) != 0) begin
                it.load_heading = 16'($urandom_range(0, FULL_CIRCLE) - HALF_CIRCLE);
            end
        end else begin
            it.op = OP_UPDATE;
            r     = $urandom_range(0, 99);
            if (r < 70) begin
                it.motion = ($urandom_range(0, 1) != 0) ? MOTION_FWD : MOTION_BWD;
            end else if (r < 80) begin
                it.motion = MOTION_STOP;
            end else if (r < 90) begin
                it.motion = ($urandom_range(0, 1) != 0) ? MOTION_LEFT : MOTION_RIGHT;
            end else begin
                it.motion = 3'($urandom_range(MOTION_HOLD_LO, MOTION_HOLD_HI));
            end
            if ($urandom_range(0, 99) < 85) begin
                it.measured_heading = 16'($urandom_range(0, FULL_CIRCLE) - HALF_CIRCLE);
            end
            if ($urandom_range(0, 1) != 0) begin
                it.left_travel  = 16'($urandom_range(0, 4000) - 2000);
                it.right_travel = 16'($urandom_range(0, 4000) - 2000);
            end
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (book.outstanding() != 0);
    endtask

    task automatic run_directed();
        send_item(update_item(MOTION_STOP, 16'sd0, 16'sd0, 16'sd0));
        send_item(update_item(MOTION_FWD, 16'sd0, 16'sh7fff, 16'sh7fff));
        send_item(update_item(MOTION_FWD, -16'sd11520, 16'sd100, 16'sd300));
        send_item(update_item(MOTION_BWD, 16'sd23040, 16'sh8000, 16'sh8000));
        send_item(update_item(MOTION_LEFT, -16'sd23040, 16'sd5, 16'sd5));
        send_item(update_item(MOTION_RIGHT, 16'sd23040, 16'sd77, -16'sd77));
        send_item(update_item(MOTION_HOLD_LO, 16'sd1234, 16'sd900, 16'sd900));
        send_item(update_item(3'(MOTION_HOLD_LO + 1), -16'sd1234, 16'sd900, 16'sd900));
        send_item(update_item(MOTION_HOLD_HI, 16'sh7fff, 16'sh8000, 16'sh7fff));
        // negation overflow, heading reduced modulo the circle
        send_item(update_item(MOTION_FWD, 16'sh8000, 16'sd4000, -16'sd1000));
        send_item(update_item(MOTION_BWD, 16'sh7fff, 16'sd1000, 16'sd1000));
        send_item(load_item(POS_MAX, POS_MIN, 16'(HALF_CIRCLE)));
        send_item(update_item(MOTION_FWD, 16'sd0, 16'sh7fff, 16'sh7fff));
        send_item(update_item(MOTION_FWD, 16'sd11520, 16'sh7fff, 16'sh7fff));
        send_item(load_item(POS_MIN, POS_MAX, 16'(-HALF_CIRCLE)));
        send_item(update_item(MOTION_BWD, 16'sd0, 16'sh7fff, 16'sh7fff));
        send_item(update_item(MOTION_BWD, 16'sd11520, 16'sh8000, 16'sh8000));
        send_item(load_item(32'sd0, 32'sd0, HEADING_MIN));
        send_item(load_item(-32'sd1, 32'sd1, HEADING_MAX));
        send_item(update_item(MOTION_FWD, 16'sd100, 16'sh8000, 16'sh7fff));
        send_item(update_item(MOTION_BWD, -16'sd23039, 16'sh7fff, 16'sh8000));
    endtask

    initial begin
        book = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        drain();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet <= (n >= 500 && n < 800);
            if (n == 1200) begin
                drain();
            end
            send_item(draw_item());
        end
        drain();
        repeat (12) @(posedge aclk);
        if (book.mismatch_count == 0 && book.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
